// File: hw/rtl/pbi_pkg.sv
// Package for the piecewise Bezier interpolator.
// Word types, operation and status codes, size constants. No dependencies.
package pbi_pkg;

	localparam int MAX_SEGMENTS_DEF = 16;
	localparam int QUEUE_DEPTH_DEF  = 4;
	localparam int T_BITS           = 30;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [1:0] CFG_SEG_COUNT = 2'd0;
	localparam logic [1:0] CFG_TOLERANCE = 2'd1;
	localparam logic [1:0] CFG_ITER_LIM  = 2'd2;

	localparam logic [1:0] STAT_OK     = 2'd0;
	localparam logic [1:0] STAT_LOW    = 2'd1;
	localparam logic [1:0] STAT_HIGH   = 2'd2;
	localparam logic [1:0] STAT_NOCONV = 2'd3;

	typedef struct packed {
		logic               operation;
		logic [3:0]         segment;
		logic [1:0]         point_index;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] query_x;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] result_y;
		logic [1:0]         status;
		logic [7:0]         iterations_used;
	} out_word_t;

	// classified command between front and back
	typedef struct packed {
		logic               is_query;
		logic [3:0]         segment;
		logic [1:0]         point_index;
		logic [63:0]        point;
		logic signed [31:0] query_x;
	} cmd_t;

	typedef struct packed {
		logic [15:0] tolerance;
		logic [7:0]  iteration_limit;
	} solve_cfg_t;

endpackage

// File: hw/rtl/pbi_front.sv
// Front end: input register, decode, drops loads beyond the table.
// Depends on pbi_pkg.
module pbi_front #(
	parameter int MAX_SEGMENTS = pbi_pkg::MAX_SEGMENTS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	output logic             cmd_stall,
	input  pbi_pkg::in_word_t cmd_word,
	output logic             push_valid,
	input  logic             push_full,
	output pbi_pkg::cmd_t    push_cmd
);
	import pbi_pkg::*;

	logic valid_s1;
	logic keep_s1;
	cmd_t cmd_s1;
	logic keep;

	assign keep = (cmd_word.operation == OP_QUERY) ||
		(32'(cmd_word.segment) < 32'(MAX_SEGMENTS));
	assign cmd_stall  = valid_s1 && keep_s1 && push_full;
	assign push_valid = valid_s1 && keep_s1;
	assign push_cmd   = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			keep_s1  <= 1'b0;
		end else if (!cmd_stall) begin
			valid_s1 <= cmd_valid;
			keep_s1  <= keep;
		end
	end

	always_ff @(posedge clk) begin
		if (!cmd_stall) begin
			cmd_s1.is_query    <= (cmd_word.operation == OP_QUERY);
			cmd_s1.segment     <= cmd_word.segment;
			cmd_s1.point_index <= cmd_word.point_index;
			cmd_s1.point       <= {cmd_word.point_y, cmd_word.point_x};
			cmd_s1.query_x     <= cmd_word.query_x;
		end
	end

endmodule

// File: hw/rtl/pbi_queue.sv
// Command queue between front and back end.
// Depends on pbi_pkg.
module pbi_queue #(
	parameter int DEPTH = pbi_pkg::QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  pbi_pkg::cmd_t push_cmd,
	output logic          full,
	output logic          pop_valid,
	input  logic          pop,
	output pbi_pkg::cmd_t pop_cmd
);
	import pbi_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          slot_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full      = (cnt_q == CW'(DEPTH));
	assign pop_valid = (cnt_q != '0);
	assign pop_cmd   = slot_q[rd_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (do_pop)
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_q] <= push_cmd;
	end

endmodule

// File: hw/rtl/pbi_back.sv
// Back end: control point memory, segment search, Newton solver with
// shared lerp multiplier and restoring divider. Depends on pbi_pkg.
module pbi_back #(
	parameter int MAX_SEGMENTS = pbi_pkg::MAX_SEGMENTS_DEF,
	localparam int SW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_pop,
	input  pbi_pkg::cmd_t       cmd,
	input  logic [SW-1:0]       seg_last,
	input  pbi_pkg::solve_cfg_t cfg,
	output logic                res_valid,
	input  logic                res_stall,
	output pbi_pkg::out_word_t  res_word
);
	import pbi_pkg::*;

	localparam int AW    = SW + 2;
	localparam int DEPTH = MAX_SEGMENTS * 4;

	localparam logic [3:0] ST_IDLE     = 4'd0;
	localparam logic [3:0] ST_FIRST    = 4'd1;
	localparam logic [3:0] ST_FIRST_CK = 4'd2;
	localparam logic [3:0] ST_SRCH     = 4'd3;
	localparam logic [3:0] ST_SRCH_CK  = 4'd4;
	localparam logic [3:0] ST_LDRD     = 4'd5;
	localparam logic [3:0] ST_LDWR     = 4'd6;
	localparam logic [3:0] ST_EVAL     = 4'd7;
	localparam logic [3:0] ST_TEST     = 4'd8;
	localparam logic [3:0] ST_DIV      = 4'd9;
	localparam logic [3:0] ST_UPD      = 4'd10;
	localparam logic [3:0] ST_OUT      = 4'd11;

	localparam logic [30:0] T_ONE = 31'(1) << T_BITS;

	logic [63:0]        mem [DEPTH];
	logic [63:0]        rd_q;
	logic [AW-1:0]      rd_addr;
	logic [AW-1:0]      wr_addr;
	logic [31:0]        wr_full;

	logic [3:0]         state_q;
	logic [SW-1:0]      seg_q;
	logic [1:0]         pt_q;
	logic signed [31:0] x_q;
	logic signed [31:0] xs_q [4];
	logic signed [31:0] ys_q [4];
	logic signed [31:0] w_q [6];
	logic [2:0]         e_q;
	logic               ph_q;
	logic               eval_y_q;
	logic [30:0]        t_q;
	logic [30:0]        t_old_q;
	logic [7:0]         iters_q;
	logic signed [32:0] f_q;
	logic signed [34:0] fp_q;
	logic [35:0]        rem_q;
	logic [31:0]        quo_q;
	logic [4:0]         cnt_q;
	logic signed [31:0] y_q;
	logic [1:0]         st_q;
	logic [7:0]         it_q;
	logic               out_valid_q;
	out_word_t          out_q;

	logic signed [31:0] pa, pb, a_sel, b_sel;
	logic signed [32:0] diff;
	logic signed [64:0] prod_full;
	logic signed [63:0] prod_s1;
	logic signed [31:0] a_s1;
	logic signed [63:0] prod_rnd;
	logic signed [63:0] prod_sh;
	logic signed [31:0] lerp_r;
	logic signed [32:0] f_new;
	logic signed [34:0] d35;
	logic [32:0]        magf;
	logic [34:0]        magfp;
	logic               over_tol;
	logic               sat;
	logic               nbit;
	logic [36:0]        rem2;
	logic               ge;
	logic [36:0]        rem_sub;
	logic [31:0]        m;
	logic               neg;
	logic signed [33:0] tn;
	logic [30:0]        tc;
	logic [31:0]        tsum;
	logic [30:0]        t_next;
	logic               out_free;
	logic               rd_x_le, rd_x_eq, rd_x_lt;

	assign wr_full = {26'd0, cmd.segment, cmd.point_index};
	assign wr_addr = wr_full[AW-1:0];
	assign cmd_pop = (state_q == ST_IDLE) && cmd_valid;
	assign out_free = !out_valid_q || !res_stall;
	assign res_valid = out_valid_q;
	assign res_word  = out_q;

	always_comb begin
		case (state_q)
			ST_SRCH: rd_addr = {seg_q, 2'b11};
			ST_LDRD: rd_addr = {seg_q, pt_q};
			default: rd_addr = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd_pop && !cmd.is_query)
			mem[wr_addr] <= cmd.point;
		rd_q <= mem[rd_addr];
	end

	assign rd_x_le = x_q <= $signed(rd_q[31:0]);
	assign rd_x_eq = x_q == $signed(rd_q[31:0]);
	assign rd_x_lt = x_q <  $signed(rd_q[31:0]);

	// lerp operands
	always_comb begin
		pa = eval_y_q ? ys_q[0] : xs_q[0];
		pb = eval_y_q ? ys_q[1] : xs_q[1];
		case (e_q)
			3'd0: begin a_sel = pa; b_sel = pb; end
			3'd1: begin
				a_sel = eval_y_q ? ys_q[1] : xs_q[1];
				b_sel = eval_y_q ? ys_q[2] : xs_q[2];
			end
			3'd2: begin
				a_sel = eval_y_q ? ys_q[2] : xs_q[2];
				b_sel = eval_y_q ? ys_q[3] : xs_q[3];
			end
			3'd3: begin a_sel = w_q[0]; b_sel = w_q[1]; end
			3'd4: begin a_sel = w_q[1]; b_sel = w_q[2]; end
			default: begin a_sel = w_q[3]; b_sel = w_q[4]; end
		endcase
	end

	assign diff      = 33'(b_sel) - 33'(a_sel);
	assign prod_full = diff * $signed({1'b0, t_q});
	assign prod_rnd  = prod_s1 + (64'sd1 <<< (T_BITS - 1));
	assign prod_sh   = prod_rnd >>> T_BITS;
	assign lerp_r    = a_s1 + prod_sh[31:0];
	assign f_new     = 33'(lerp_r) - 33'(x_q);
	assign d35       = 35'(w_q[4]) - 35'(w_q[3]);

	assign magf     = f_q[32] ? 33'(-f_q) : 33'(f_q);
	assign magfp    = fp_q[34] ? 35'(-fp_q) : 35'(fp_q);
	assign over_tol = magf > 33'(cfg.tolerance);
	assign sat      = 35'(magf >> 2) >= magfp;

	always_comb begin
		case (cnt_q)
			5'd0:    nbit = magf[1];
			5'd1:    nbit = magf[0];
			default: nbit = 1'b0;
		endcase
	end
	assign rem2    = {rem_q, nbit};
	assign ge      = rem2 >= 37'(magfp);
	assign rem_sub = rem2 - 37'(magfp);

	assign m    = (quo_q > 32'h8000_0000) ? 32'h8000_0000 : quo_q;
	assign neg  = f_q[32] != fp_q[34];
	assign tn   = neg ? 34'(t_q) + 34'(m) : 34'(t_q) - 34'(m);
	assign tc   = tn[33] ? '0 : ((tn > 34'(T_ONE)) ? T_ONE : tn[30:0]);
	assign tsum = 32'(tc) + 32'(t_q);
	assign t_next = (tc == t_old_q) ? tsum[31:1] : tc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_OUT && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !res_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE:
					if (cmd_valid && cmd.is_query)
						state_q <= ST_FIRST;
				ST_FIRST: state_q <= ST_FIRST_CK;
				ST_FIRST_CK:
					state_q <= rd_x_le ? ST_OUT : ST_SRCH;
				ST_SRCH: state_q <= ST_SRCH_CK;
				ST_SRCH_CK:
					if (rd_x_eq)
						state_q <= ST_OUT;
					else if (rd_x_lt)
						state_q <= ST_LDRD;
					else if (seg_q == seg_last)
						state_q <= ST_OUT;
					else
						state_q <= ST_SRCH;
				ST_LDRD: state_q <= ST_LDWR;
				ST_LDWR:
					state_q <= (pt_q == 2'd3) ? ST_EVAL : ST_LDRD;
				ST_EVAL:
					if (ph_q && e_q == 3'd5)
						state_q <= eval_y_q ? ST_OUT : ST_TEST;
				ST_TEST:
					if (over_tol && iters_q < cfg.iteration_limit)
						state_q <= sat ? ST_UPD : ST_DIV;
					else
						state_q <= ST_EVAL;
				ST_DIV:
					if (cnt_q == 5'd31)
						state_q <= ST_UPD;
				ST_UPD: state_q <= ST_EVAL;
				ST_OUT:
					if (out_free)
						state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= prod_full[63:0];
		a_s1    <= a_sel;
		case (state_q)
			ST_IDLE: begin
				x_q   <= cmd.query_x;
				seg_q <= '0;
			end
			ST_FIRST_CK: begin
				y_q  <= $signed(rd_q[63:32]);
				st_q <= STAT_LOW;
				it_q <= '0;
			end
			ST_SRCH_CK: begin
				y_q  <= $signed(rd_q[63:32]);
				st_q <= STAT_HIGH;
				it_q <= '0;
				pt_q <= '0;
				if (!rd_x_eq && !rd_x_lt)
					seg_q <= seg_q + 1'b1;
			end
			ST_LDWR: begin
				xs_q[pt_q] <= $signed(rd_q[31:0]);
				ys_q[pt_q] <= $signed(rd_q[63:32]);
				pt_q       <= pt_q + 1'b1;
				t_q        <= '0;
				t_old_q    <= '0;
				iters_q    <= '0;
				eval_y_q   <= 1'b0;
				e_q        <= '0;
				ph_q       <= 1'b0;
			end
			ST_EVAL: begin
				ph_q <= !ph_q;
				if (ph_q) begin
					w_q[e_q] <= lerp_r;
					e_q      <= e_q + 1'b1;
					if (e_q == 3'd5) begin
						if (eval_y_q) begin
							y_q  <= lerp_r;
							st_q <= over_tol ? STAT_NOCONV : STAT_OK;
							it_q <= iters_q;
						end else begin
							f_q  <= f_new;
							fp_q <= (d35 <<< 1) + d35;
						end
					end
				end
			end
			ST_TEST: begin
				rem_q    <= 36'(magf >> 2);
				quo_q    <= sat ? 32'h8000_0000 : '0;
				cnt_q    <= '0;
				e_q      <= '0;
				ph_q     <= 1'b0;
				eval_y_q <= 1'b1;
			end
			ST_DIV: begin
				rem_q <= ge ? rem_sub[35:0] : rem2[35:0];
				quo_q <= {quo_q[30:0], ge};
				cnt_q <= cnt_q + 1'b1;
			end
			ST_UPD: begin
				t_old_q   <= t_q;
				t_q       <= t_next;
				iters_q   <= iters_q + 1'b1;
				eval_y_q  <= 1'b0;
				e_q       <= '0;
				ph_q      <= 1'b0;
			end
			ST_OUT:
				if (out_free) begin
					out_q.result_y        <= y_q;
					out_q.status          <= st_q;
					out_q.iterations_used <= it_q;
				end
			default: ;
		endcase
	end

endmodule

// File: hw/rtl/piecewise_bezier_interpolator_unit.sv
// Piecewise cubic Bezier interpolator, top level.
// Command words on cmd_*, result words on res_*, register writes on cfg_*.
// Load words (operation 0) write one control point and give no result.
// Query words (operation 1) give one result word: y, status, Newton steps.
// Registers: 0 segment count, 1 tolerance, 2 iteration limit; cfg_ready
// is always high. Write them only while no word is in flight.
// A command passes an input register and a four-word queue, then the back
// end handles one word at a time. A load is written to the control point
// memory as the back end pops it. A query first scans segments to find its
// own, then fetches its four points and evaluates the curve on the shared
// lerp multiplier; each Newton step evaluates the curve again and runs the
// restoring divide, which is skipped on a saturated step.
// Reset empties the queue and the result register; the control point
// memory is not cleared and must be loaded before it is queried.
// While res_stall is high the result word holds, the back end waits in its
// output step, and the queue fills until cmd_stall rises.
// Depends on pbi_pkg, pbi_front, pbi_queue, pbi_back.
module piecewise_bezier_interpolator_unit #(
	parameter int MAX_SEGMENTS = pbi_pkg::MAX_SEGMENTS_DEF,
	parameter int QUEUE_DEPTH  = pbi_pkg::QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  pbi_pkg::in_word_t  cmd_word,
	output logic               res_valid,
	input  logic               res_stall,
	output pbi_pkg::out_word_t res_word,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	import pbi_pkg::*;

	localparam int SW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

	logic [4:0]  seg_count_q;
	solve_cfg_t  cfg_q;
	int          n_eff;
	logic [31:0] n_last;
	logic        push_valid, q_full, q_valid, q_pop;
	cmd_t        push_cmd, q_cmd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_count_q           <= 5'd1;
			cfg_q.tolerance       <= 16'd1;
			cfg_q.iteration_limit <= 8'd100;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SEG_COUNT: seg_count_q           <= cfg_data[4:0];
				CFG_TOLERANCE: cfg_q.tolerance       <= cfg_data[15:0];
				CFG_ITER_LIM:  cfg_q.iteration_limit <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (seg_count_q == '0)
			n_eff = 1;
		else if (int'(seg_count_q) > MAX_SEGMENTS)
			n_eff = MAX_SEGMENTS;
		else
			n_eff = int'(seg_count_q);
		n_last = 32'(n_eff - 1);
	end

	pbi_front #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_front (
		.clk, .arst_n,
		.cmd_valid, .cmd_stall, .cmd_word,
		.push_valid, .push_full(q_full), .push_cmd
	);

	pbi_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk, .arst_n,
		.push(push_valid), .push_cmd, .full(q_full),
		.pop_valid(q_valid), .pop(q_pop), .pop_cmd(q_cmd)
	);

	pbi_back #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_back (
		.clk, .arst_n,
		.cmd_valid(q_valid), .cmd_pop(q_pop), .cmd(q_cmd),
		.seg_last(n_last[SW-1:0]), .cfg(cfg_q),
		.res_valid, .res_stall, .res_word
	);

	a_iter_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_word.iterations_used <= cfg_q.iteration_limit)
		else $error("iteration count above limit");

	a_short_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_word.status == STAT_LOW || res_word.status == STAT_HIGH)
		|-> res_word.iterations_used == 8'd0)
		else $error("short case reports Newton steps");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> q_full && push_valid)
		else $error("front stalls without a full queue");

endmodule
